>>> hw/rtl/vvpt_pkg.sv
package vvpt_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int OUT_W  = 32;  // screen field width
  localparam int CAM_W  = 37;  // camera point
  localparam int MUL_W  = 61;  // projection product
  localparam int V_W    = 46;  // clip coordinate before divide
  localparam int DIV_W  = 37;  // divisor magnitude |w|
  localparam int Q_W    = 32;  // quotient bits kept
  localparam int NUM_LANES = 3;
  localparam int IDX_W  = 4;

  localparam logic [IDX_W-1:0] REG_ROT_X      = 4'd0;
  localparam logic [IDX_W-1:0] REG_ROT_Y      = 4'd1;
  localparam logic [IDX_W-1:0] REG_ROT_Z      = 4'd2;
  localparam logic [IDX_W-1:0] REG_TRANS_X    = 4'd3;
  localparam logic [IDX_W-1:0] REG_TRANS_Y    = 4'd4;
  localparam logic [IDX_W-1:0] REG_TRANS_Z    = 4'd5;
  localparam logic [IDX_W-1:0] REG_PROJ_XY    = 4'd6;
  localparam logic [IDX_W-1:0] REG_PROJ_DEPTH = 4'd7;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             fixed;   // result known without the divide
    logic [OUT_W-1:0] fval;
    logic             fhit;
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    logic             wzero;
    logic [DIV_W-1:0] d;
    div_lane_t [NUM_LANES-1:0] lane;
  } div_bus_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_v(logic signed [V_W-1:0] v,
                                 logic signed [V_W-1:0] hi,
                                 logic signed [V_W-1:0] lo);
    sat_t r;
    r.hit = 1'b0;
    r.val = v[OUT_W-1:0];
    if (v > hi) begin
      r.hit = 1'b1;
      r.val = hi[OUT_W-1:0];
    end
    if (v < lo) begin
      r.hit = 1'b1;
      r.val = lo[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/vvpt_view.sv
module vvpt_view
  import vvpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [31:0]      wx,
  input  logic signed [31:0]      wy,
  input  logic signed [31:0]      wz,
  input  logic [53:0]             rot [NUM_LANES],
  input  logic signed [31:0]      trans [NUM_LANES],
  output logic                    out_v,
  output logic signed [CAM_W-1:0] cam [NUM_LANES]
);

  logic signed [49:0] prod_r [NUM_LANES][3];
  logic signed [49:0] prod_nxt [NUM_LANES][3];
  logic               v1_r, v2_r;
  logic signed [CAM_W-1:0] cam_r [NUM_LANES];
  logic signed [CAM_W-1:0] cam_nxt [NUM_LANES];
  logic signed [31:0] wv [3];
  logic signed [51:0] sum [NUM_LANES];

  assign wv[0] = wx;
  assign wv[1] = wy;
  assign wv[2] = wz;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[l][k] = $signed(rot[l][18*k +: 18]) * wv[k];
      end
      sum[l] = {{2{prod_r[l][0][49]}}, prod_r[l][0]} + {{2{prod_r[l][1][49]}}, prod_r[l][1]}
             + {{2{prod_r[l][2][49]}}, prod_r[l][2]};
      cam_nxt[l] = {sum[l][51], sum[l][51:16]} + {{(CAM_W-32){trans[l][31]}}, trans[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
    if (en) begin
      prod_r <= prod_nxt;
      cam_r  <= cam_nxt;
    end
  end

  assign out_v = v2_r;
  assign cam   = cam_r;

endmodule

>>> hw/rtl/vvpt_proj.sv
module vvpt_proj
  import vvpt_pkg::*;
#(
  parameter int SAT_BITS = DEF_COORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [CAM_W-1:0] cam [NUM_LANES],
  input  logic [47:0]             proj_xy,
  input  logic [55:0]             proj_depth,
  output div_bus_t                bus
);

  localparam logic signed [V_W-1:0] SAT_HI = V_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
  localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

  logic signed [MUL_W-1:0] mul_r [NUM_LANES];
  logic signed [MUL_W-1:0] mul_nxt [NUM_LANES];
  logic signed [CAM_W:0]   w_r;
  logic                    v3_r;
  div_bus_t                bus_r, bus_nxt;
  logic signed [23:0]      pcoef [NUM_LANES];
  logic signed [31:0]      p23;
  logic signed [V_W-1:0]   vv [NUM_LANES];
  logic [V_W-1:0]          vmag [NUM_LANES];
  logic [CAM_W:0]          wabs;
  logic [DIV_W-1:0]        wmag;
  logic                    wneg, wz, ovf;
  sat_t                    s;

  assign pcoef[0] = proj_xy[23:0];
  assign pcoef[1] = proj_xy[47:24];
  assign pcoef[2] = proj_depth[23:0];
  assign p23      = proj_depth[55:24];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mul_nxt[l] = pcoef[l] * cam[l];
    end
  end

  always_comb begin
    vv[0] = {mul_r[0][MUL_W-1], mul_r[0][MUL_W-1:16]};
    vv[1] = {mul_r[1][MUL_W-1], mul_r[1][MUL_W-1:16]};
    vv[2] = {mul_r[2][MUL_W-1], mul_r[2][MUL_W-1:16]} + {{(V_W-32){p23[31]}}, p23};
    wneg = w_r[CAM_W];
    wabs = wneg ? -w_r : w_r;
    wmag = wabs[DIV_W-1:0];
    wz   = (w_r == '0);
    bus_nxt.valid = v3_r;
    bus_nxt.wzero = wz;
    bus_nxt.d     = wmag;
    for (int l = 0; l < NUM_LANES; l++) begin
      vmag[l] = vv[l][V_W-1] ? -vv[l] : vv[l];
      ovf = {8'b0, vmag[l]} >= {1'b0, wmag, 16'b0};
      s = sat_v(vv[l], SAT_HI, SAT_LO);
      bus_nxt.lane[l].rem   = {7'b0, vmag[l][V_W-1:16]};
      bus_nxt.lane[l].nlo   = {vmag[l][15:0], 16'b0};
      bus_nxt.lane[l].q     = '0;
      bus_nxt.lane[l].neg   = vv[l][V_W-1] ^ wneg;
      bus_nxt.lane[l].fixed = wz | ovf;
      if (wz) begin
        bus_nxt.lane[l].fval = s.val;
        bus_nxt.lane[l].fhit = s.hit;
      end else begin
        bus_nxt.lane[l].fval = (vv[l][V_W-1] ^ wneg) ? SAT_LO[OUT_W-1:0] : SAT_HI[OUT_W-1:0];
        bus_nxt.lane[l].fhit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      bus_r.valid <= 1'b0;
    end else if (en) begin
      v3_r        <= in_v;
      bus_r.valid <= bus_nxt.valid;
    end
    if (en) begin
      mul_r <= mul_nxt;
      w_r   <= -{cam[2][CAM_W-1], cam[2]};
      bus_r.wzero <= bus_nxt.wzero;
      bus_r.d     <= bus_nxt.d;
      bus_r.lane  <= bus_nxt.lane;
    end
  end

  assign bus = bus_r;

endmodule

>>> hw/rtl/vvpt_div_stage.sv
module vvpt_div_stage
  import vvpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_bus_t bus_in,
  output div_bus_t bus_out
);

  div_bus_t         bus_r, bus_nxt;
  logic [DIV_W:0]   trial [NUM_LANES];

  // one quotient bit per lane: shift in next dividend bit, subtract if it fits
  always_comb begin
    bus_nxt = bus_in;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial[l] = {bus_in.lane[l].rem, bus_in.lane[l].nlo[Q_W-1]};
      bus_nxt.lane[l].nlo = {bus_in.lane[l].nlo[Q_W-2:0], 1'b0};
      if (trial[l] >= {1'b0, bus_in.d}) begin
        bus_nxt.lane[l].rem = DIV_W'(trial[l] - {1'b0, bus_in.d});
        bus_nxt.lane[l].q   = {bus_in.lane[l].q[Q_W-2:0], 1'b1};
      end else begin
        bus_nxt.lane[l].rem = trial[l][DIV_W-1:0];
        bus_nxt.lane[l].q   = {bus_in.lane[l].q[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r.valid <= bus_nxt.valid;
    end
    if (en) begin
      bus_r.wzero <= bus_nxt.wzero;
      bus_r.d     <= bus_nxt.d;
      bus_r.lane  <= bus_nxt.lane;
    end
  end

  assign bus_out = bus_r;

endmodule

>>> hw/rtl/vertex_view_projection_transform.sv
// Perspective vertex transform with divide.
// Input channel in_*: one world vertex (Q16.16 x, y, z) per transaction.
// Result channel out_*: screen x, y, z (Q16.16, saturated to COORD_WIDTH
// bits, at most 32, sign-extended), w_was_zero and clamped.
// Config channel cfg_*: index 0..7 selects rotation rows, translation,
// projection scale and depth terms; other indexes are ignored. Write only
// while the pipeline is empty. cfg_ready is always high.
// Pipeline: the result passes through 37 register stages: two view stages,
// two projection stages, 32 divider stages (one quotient bit per stage
// across three lanes) and the output register.
// Throughput: one vertex per cycle unless stalled; the 32-stage divider
// is fully pipelined.
// Reset: all valid bits clear, registers load identity view and a unit
// projection (p22 = -1).
// Stall: when the result waits and out_ready is low, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
module vertex_view_projection_transform
  import vvpt_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [OUT_W-1:0] in_world_x,
  input  logic signed [OUT_W-1:0] in_world_y,
  input  logic signed [OUT_W-1:0] in_world_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_screen_x,
  output logic signed [OUT_W-1:0] out_screen_y,
  output logic signed [OUT_W-1:0] out_screen_z,
  output logic                    out_w_was_zero,
  output logic                    out_clamped,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [63:0]             cfg_data
);

  localparam int SAT_BITS = (COORD_WIDTH > OUT_W) ? OUT_W : COORD_WIDTH;
  localparam logic signed [V_W-1:0] SAT_HI = V_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
  localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

  logic [53:0]        rot_r [NUM_LANES];
  logic signed [31:0] trans_r [NUM_LANES];
  logic [47:0]        proj_xy_r;
  logic [55:0]        proj_depth_r;

  logic                    en;
  logic                    cam_v;
  logic signed [CAM_W-1:0] cam [NUM_LANES];
  div_bus_t                chain [Q_W+1];

  logic             out_valid_r;
  logic [OUT_W-1:0] sx_r, sy_r, sz_r;
  logic             wzero_r, clamped_r;
  sat_t             res [NUM_LANES];
  logic signed [V_W-1:0] sv [NUM_LANES];
  logic [OUT_W-1:0] val_nxt [NUM_LANES];
  logic             hit_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]     <= 54'd65536;
      rot_r[1]     <= 54'd17179869184;
      rot_r[2]     <= 54'd4503599627370496;
      trans_r[0]   <= '0;
      trans_r[1]   <= '0;
      trans_r[2]   <= '0;
      proj_xy_r    <= 48'd1099511693312;
      proj_depth_r <= 56'd16711680;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT_X:      rot_r[0]     <= cfg_data[53:0];
        REG_ROT_Y:      rot_r[1]     <= cfg_data[53:0];
        REG_ROT_Z:      rot_r[2]     <= cfg_data[53:0];
        REG_TRANS_X:    trans_r[0]   <= cfg_data[31:0];
        REG_TRANS_Y:    trans_r[1]   <= cfg_data[31:0];
        REG_TRANS_Z:    trans_r[2]   <= cfg_data[31:0];
        REG_PROJ_XY:    proj_xy_r    <= cfg_data[47:0];
        REG_PROJ_DEPTH: proj_depth_r <= cfg_data[55:0];
        default: ;
      endcase
    end
  end

  vvpt_view u_view (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid && in_ready),
    .wx    (in_world_x),
    .wy    (in_world_y),
    .wz    (in_world_z),
    .rot   (rot_r),
    .trans (trans_r),
    .out_v (cam_v),
    .cam   (cam)
  );

  vvpt_proj #(
    .SAT_BITS (SAT_BITS)
  ) u_proj (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (cam_v),
    .cam        (cam),
    .proj_xy    (proj_xy_r),
    .proj_depth (proj_depth_r),
    .bus        (chain[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    vvpt_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .bus_in  (chain[i]),
      .bus_out (chain[i+1])
    );
  end

  always_comb begin
    hit_nxt = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      sv[l] = chain[Q_W].lane[l].neg ? -{{(V_W-Q_W){1'b0}}, chain[Q_W].lane[l].q}
                                     :  {{(V_W-Q_W){1'b0}}, chain[Q_W].lane[l].q};
      res[l] = sat_v(sv[l], SAT_HI, SAT_LO);
      if (chain[Q_W].lane[l].fixed) begin
        val_nxt[l] = chain[Q_W].lane[l].fval;
        hit_nxt    = hit_nxt | chain[Q_W].lane[l].fhit;
      end else begin
        val_nxt[l] = res[l].val;
        hit_nxt    = hit_nxt | res[l].hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[Q_W].valid;
    end
    if (en) begin
      sx_r      <= val_nxt[0];
      sy_r      <= val_nxt[1];
      sz_r      <= val_nxt[2];
      wzero_r   <= chain[Q_W].wzero;
      clamped_r <= hit_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_screen_x   = sx_r;
  assign out_screen_y   = sy_r;
  assign out_screen_z   = sz_r;
  assign out_w_was_zero = wzero_r;
  assign out_clamped    = clamped_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |->
      out_screen_x == SAT_HI[OUT_W-1:0] || out_screen_x == SAT_LO[OUT_W-1:0] ||
      out_screen_y == SAT_HI[OUT_W-1:0] || out_screen_y == SAT_LO[OUT_W-1:0] ||
      out_screen_z == SAT_HI[OUT_W-1:0] || out_screen_z == SAT_LO[OUT_W-1:0])
    else $error("clamped without a saturated coordinate");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vvpt_pkg::*;

  localparam int N_RANDOM = 750;
  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } vertex_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               wzero;
    logic               clamped;
  } screen_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_y = '0;
  logic signed [31:0] in_world_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_screen_x, out_screen_y, out_screen_z;
  logic out_w_was_zero, out_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  vertex_view_projection_transform dut (.*);

  always #1 clk = ~clk;

  logic [63:0] view_regs [8];
  vertex_t pending_vertices [$];
  screen_t expected_screen [$];
  int errors = 0;
  longint cycle = 0;
  bit idle_enable = 1'b1;
  bit send_hold = 1'b0;
  int recv_hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic in_ready_q = 1'b0;

  function automatic longint sfield(logic [63:0] v, int pos, int bits);
    logic [63:0] f;
    f = (v >> pos) & ((64'd1 << bits) - 64'd1);
    if (f[bits-1]) f = f | ~((64'd1 << bits) - 64'd1);
    return longint'(f);
  endfunction

  function automatic longint shr16(longint v);
    return v >>> 16;
  endfunction

  function automatic logic [31:0] clip32(longint v, ref logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
    return shr16(sfield(row, 0, 18) * x + sfield(row, 18, 18) * y
                 + sfield(row, 36, 18) * z);
  endfunction

  function automatic screen_t project_vertex(vertex_t v);
    screen_t r;
    longint cx, cy, cz, vx, vy, vz, w;
    logic hit;
    cx = row_dot(view_regs[0], v.wx, v.wy, v.wz) + sfield(view_regs[3], 0, 32);
    cy = row_dot(view_regs[1], v.wx, v.wy, v.wz) + sfield(view_regs[4], 0, 32);
    cz = row_dot(view_regs[2], v.wx, v.wy, v.wz) + sfield(view_regs[5], 0, 32);
    vx = shr16(sfield(view_regs[6], 0, 24) * cx);
    vy = shr16(sfield(view_regs[6], 24, 24) * cy);
    vz = shr16(sfield(view_regs[7], 0, 24) * cz) + sfield(view_regs[7], 24, 32);
    w = -cz;
    hit = 1'b0;
    r.wzero = (w == 0);
    if (!r.wzero) begin
      // SV division truncates toward zero
      vx = (vx * 65536) / w;
      vy = (vy * 65536) / w;
      vz = (vz * 65536) / w;
    end
    r.sx = clip32(vx, hit);
    r.sy = clip32(vy, hit);
    r.sz = clip32(vz, hit);
    r.clamped = hit;
    return r;
  endfunction

  function automatic logic [63:0] reg_mask(int idx);
    case (idx)
      REG_ROT_X, REG_ROT_Y, REG_ROT_Z: return (64'd1 << 54) - 1;
      REG_PROJ_XY: return (64'd1 << 48) - 1;
      REG_PROJ_DEPTH: return (64'd1 << 56) - 1;
      default: return 64'hffffffff;
    endcase
  endfunction

  // driver: falling edge, feeds pending vertices
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_q) begin
        expected_screen.push_back(project_vertex(pending_vertices.pop_front()));
      end
      if (!(in_valid && !in_ready_q)) begin
        if (send_gap > 0) send_gap--;
        if (pending_vertices.size() > 0 && !send_hold && send_gap == 0 &&
            !(idle_enable && $urandom_range(0, 15) == 0)) begin
          in_valid <= 1'b1;
          in_world_x <= pending_vertices[0].wx;
          in_world_y <= pending_vertices[0].wy;
          in_world_z <= pending_vertices[0].wz;
        end else begin
          in_valid <= 1'b0;
          if (idle_enable && send_gap == 0 && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 9);
        end
      end
      if (recv_hold_cycles > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver hold, counted down once per cycle
  always @(posedge clk) begin
    if (recv_hold_cycles > 0) recv_hold_cycles--;
  end

  // accept flag sampled at the rising edge
  always @(posedge clk) begin
    cycle++;
    in_ready_q <= in_valid && in_ready;
    if (cycle > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // monitor
  always @(posedge clk) begin
    screen_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_screen.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_screen.pop_front();
        if (out_screen_x !== e.sx) begin
          $error("screen_x exp %0d got %0d", e.sx, out_screen_x); errors++;
        end
        if (out_screen_y !== e.sy) begin
          $error("screen_y exp %0d got %0d", e.sy, out_screen_y); errors++;
        end
        if (out_screen_z !== e.sz) begin
          $error("screen_z exp %0d got %0d", e.sz, out_screen_z); errors++;
        end
        if (out_w_was_zero !== e.wzero) begin
          $error("w_was_zero exp %0d got %0d", e.wzero, out_w_was_zero); errors++;
        end
        if (out_clamped !== e.clamped) begin
          $error("clamped exp %0d got %0d", e.clamped, out_clamped); errors++;
        end
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < 8) view_regs[idx] = data & reg_mask(idx);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || expected_screen.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000 + $urandom_range(0, 3);
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t v;
    v.wx = x; v.wy = y; v.wz = z;
    pending_vertices.push_back(v);
  endtask

  function automatic logic [17:0] rnd_coef();
    case ($urandom_range(0, 4))
      0: return 18'h20000;
      1: return 18'h1ffff;
      2: return 18'($urandom);
      default: return 18'($urandom_range(0, 18'h0ffff) - 18'h08000);
    endcase
  endfunction

  function automatic logic [23:0] rnd_p24();
    case ($urandom_range(0, 3))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom);
      default: return 24'($urandom_range(0, 24'h3ffff) - 24'h20000);
    endcase
  endfunction

  task automatic random_config();
    for (int r = 0; r < 3; r++)
      write_reg(r, {$urandom, $urandom} ^ {10'h0, rnd_coef(), rnd_coef(), rnd_coef()});
    for (int r = 3; r < 6; r++)
      write_reg(r, {$urandom, rnd_coord()});
    write_reg(REG_PROJ_XY, {16'($urandom), rnd_p24(), rnd_p24()} ^
              ($urandom_range(0,1) ? {$urandom, $urandom} : 64'h0));
    write_reg(REG_PROJ_DEPTH, {8'h0, rnd_coord(), rnd_p24()});
    write_reg(8 + $urandom_range(0, 7), {$urandom, $urandom});
  endtask

  initial begin
    int idx;
    for (int r = 0; r < 8; r++) view_regs[r] = 64'd0;
    view_regs[0] = 64'd65536;
    view_regs[1] = 64'd17179869184;
    view_regs[2] = 64'd4503599627370496;
    view_regs[6] = 64'd1099511693312;
    view_regs[7] = 64'd16711680;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed at reset settings: zero w, extremes, clamping
    add_vertex(32'h0, 32'h0, 32'h0);
    add_vertex(32'h00010000, 32'h00020000, 32'h0);
    add_vertex(32'h7fffffff, 32'h80000000, 32'h0);
    add_vertex(32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    add_vertex(32'h80000000, 32'h80000000, 32'h00000001);
    add_vertex(32'h00010000, 32'hffff0000, 32'hfffe0000);
    add_vertex(32'hffffffff, 32'hffffffff, 32'h7fffffff);
    add_vertex(32'h12345678, 32'hedcba987, 32'h80000000);
    add_vertex(32'h00030000, 32'h00050000, 32'hfff80000);
    add_vertex(32'hffffffff, 32'h00000001, 32'h00010000);
    drain();

    // extreme registers
    write_reg(REG_ROT_X, {10'h0, 18'h1ffff, 18'h20000, 18'h1ffff});
    write_reg(REG_ROT_Y, {10'h0, 18'h20000, 18'h1ffff, 18'h20000});
    write_reg(REG_ROT_Z, 64'hffffffffffffffff);
    write_reg(REG_TRANS_X, 64'h7fffffff);
    write_reg(REG_TRANS_Y, 64'h80000000);
    write_reg(REG_TRANS_Z, 64'hffffffff);
    write_reg(REG_PROJ_XY, {16'h0, 24'h800000, 24'h7fffff});
    write_reg(REG_PROJ_DEPTH, {8'h0, 32'h80000000, 24'h7fffff});
    write_reg(9, 64'h0);
    add_vertex(32'h0, 32'h0, 32'h0);
    add_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    add_vertex(32'h00000001, 32'h80000000, 32'h7fffffff);
    add_vertex(32'hffffffff, 32'h00000000, 32'h00000001);
    drain();
    write_reg(REG_PROJ_DEPTH, {8'h0, 32'h7fffffff, 24'h800000});
    write_reg(REG_TRANS_Z, 64'h0);
    write_reg(REG_ROT_Z, 64'h0);
    add_vertex(32'h00010000, 32'h00010000, 32'h00010000);
    add_vertex(32'h80000000, 32'h7fffffff, 32'h00000000);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      // a plain pinhole camera sometimes, so w is the negated world z
      if ($urandom_range(0, 1)) begin
        write_reg(REG_ROT_Z, {10'h0, 18'h10000, 18'h0, 18'h0});
        write_reg(REG_TRANS_Z, 64'h0);
      end
      if (ph == 7) idle_enable = 1'b0;
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        idx = $urandom_range(0, 3);
        if (idx == 0)
          add_vertex(rnd_coord(), rnd_coord(), 32'h0);
        else
          add_vertex(rnd_coord(), rnd_coord(), rnd_coord());
      end
      if (ph == 2) begin
        // long receiver hold so the pipeline fills and stalls input
        recv_hold_cycles = 150;
      end
      if (ph == 4) begin
        while (pending_vertices.size() > 40) @(posedge clk);
        send_hold = 1'b1;
        while (expected_screen.size() > 0 || in_valid) @(posedge clk);
        send_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> vertex_view_projection_transform.f
hw/rtl/vvpt_pkg.sv
hw/rtl/vvpt_view.sv
hw/rtl/vvpt_proj.sv
hw/rtl/vvpt_div_stage.sv
hw/rtl/vertex_view_projection_transform.sv
dv/tb_top.sv
